FILE: rtl/triangle_face_normal_defines.svh
`ifndef TRIANGLE_FACE_NORMAL_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define TFN_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfn check failed");

// condition that holds on every rising clock edge outside reset
`define TFN_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tfn check failed");

`endif

FILE: rtl/tfn_pkg.sv
package tfn_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int EDGE_BITS        = 15;
    localparam int OUT_WIDTH        = 16;

    localparam int MAG_W  = COORD_WIDTH;
    localparam int PAD_W  = (MAG_W > EDGE_BITS) ? MAG_W : EDGE_BITS;
    localparam int SH_W   = $clog2(MAG_W + 1);
    localparam int SQ_W   = 2 * EDGE_BITS;
    localparam int LEN_W  = SQ_W + 2;
    localparam int X_W    = LEN_W + 2 * EDGE_BITS;
    localparam int ROOT_W = (X_W + 1) / 2;
    localparam int Q_W    = NORMAL_FRAC_BITS + 1;
    localparam int REM_W  = ROOT_W + Q_W + 1;
    localparam int UNIT_W = NORMAL_FRAC_BITS + 2;
    localparam int PROD_W = 2 * UNIT_W;
    localparam int DIFF_W = PROD_W + 1;

    // start edge to strobe sample edge
    localparam int PIPE_LAT = 8 + ROOT_W + Q_W;

    typedef struct packed {
        logic                      deg;
        logic [2:0]                neg;
        logic [2:0][EDGE_BITS-1:0] m;
    } t_side;

endpackage

FILE: rtl/tfn_front.sv
module tfn_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic                                   i_deg,
    input  logic [2:0][tfn_pkg::COORD_WIDTH:0]     i_e,
    output logic                                   o_valid,
    output logic [tfn_pkg::LEN_W-1:0]              o_len,
    output tfn_pkg::t_side                         o_side
);

    logic                                r_a_v, r_b_v, r_c_v, r_d_v;
    logic                                r_a_deg, r_b_deg, r_c_deg;
    logic [2:0]                          r_a_neg, r_b_neg, r_c_neg;
    logic [2:0][tfn_pkg::MAG_W-1:0]      r_a_mag;
    logic [2:0][tfn_pkg::EDGE_BITS-1:0]  r_b_m, r_c_m;
    logic [2:0][tfn_pkg::SQ_W-1:0]       r_c_sq;
    logic [tfn_pkg::LEN_W-1:0]           r_d_len;
    tfn_pkg::t_side                      r_d_side;

    logic [2:0][tfn_pkg::MAG_W-1:0]      n_mag;
    logic [2:0]                          n_neg;
    logic [tfn_pkg::MAG_W-1:0]           mx;
    logic [tfn_pkg::SH_W-1:0]            sh;
    logic [2:0][tfn_pkg::PAD_W-1:0]      pad;

    always_comb begin
        logic signed [tfn_pkg::COORD_WIDTH:0] e;
        logic        [tfn_pkg::COORD_WIDTH:0] a;
        for (int k = 0; k < 3; k++) begin
            e = $signed(i_e[k]);
            a = (e < 0) ? -e : e;
            n_neg[k] = e[tfn_pkg::COORD_WIDTH];
            n_mag[k] = a[tfn_pkg::MAG_W-1:0];
        end
    end

    always_comb begin
        mx = r_a_mag[0];
        if (r_a_mag[1] > mx) mx = r_a_mag[1];
        if (r_a_mag[2] > mx) mx = r_a_mag[2];
        sh = '0;
        for (int s = tfn_pkg::MAG_W; s >= 0; s--) begin
            if ((mx >> s) < (tfn_pkg::MAG_W + 1)'(2 ** tfn_pkg::EDGE_BITS))
                sh = tfn_pkg::SH_W'(s);
        end
        for (int k = 0; k < 3; k++)
            pad[k] = tfn_pkg::PAD_W'(r_a_mag[k]) >> sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_mag <= n_mag;
        r_a_neg <= n_neg;
        r_a_deg <= i_deg;
        for (int k = 0; k < 3; k++)
            r_b_m[k] <= pad[k][tfn_pkg::EDGE_BITS-1:0];
        r_b_neg <= r_a_neg;
        r_b_deg <= r_a_deg;
        for (int k = 0; k < 3; k++)
            r_c_sq[k] <= r_b_m[k] * r_b_m[k];
        r_c_m   <= r_b_m;
        r_c_neg <= r_b_neg;
        r_c_deg <= r_b_deg;
        r_d_len <= tfn_pkg::LEN_W'(r_c_sq[0]) + tfn_pkg::LEN_W'(r_c_sq[1])
                 + tfn_pkg::LEN_W'(r_c_sq[2]);
        r_d_side.deg <= r_c_deg;
        r_d_side.neg <= r_c_neg;
        r_d_side.m   <= r_c_m;
    end

    assign o_valid = r_d_v;
    assign o_len   = r_d_len;
    assign o_side  = r_d_side;

endmodule

FILE: rtl/tfn_sqrt.sv
module tfn_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [tfn_pkg::LEN_W-1:0]    i_len,
    input  tfn_pkg::t_side               i_side,
    output logic                         o_valid,
    output logic [tfn_pkg::ROOT_W-1:0]   o_root,
    output tfn_pkg::t_side               o_side
);

    localparam int W = tfn_pkg::X_W + 1;
    localparam int N = tfn_pkg::ROOT_W;

    logic [W-1:0]   r_x   [N];
    logic [W-1:0]   r_res [N];
    logic           r_v   [N];
    tfn_pkg::t_side r_side[N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - k));
        logic [W-1:0]   src_x, src_res, t;
        logic           src_v;
        tfn_pkg::t_side src_side;
        if (k == 0) begin : g_first
            assign src_x    = W'(i_len) << (2 * tfn_pkg::EDGE_BITS);
            assign src_res  = '0;
            assign src_v    = i_valid;
            assign src_side = i_side;
        end else begin : g_next
            assign src_x    = r_x[k-1];
            assign src_res  = r_res[k-1];
            assign src_v    = r_v[k-1];
            assign src_side = r_side[k-1];
        end
        assign t = src_res + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (src_x >= t) begin
                r_x[k]   <= src_x - t;
                r_res[k] <= (src_res >> 1) + BIT;
            end else begin
                r_x[k]   <= src_x;
                r_res[k] <= src_res >> 1;
            end
            r_side[k] <= src_side;
        end
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_res[N-1][tfn_pkg::ROOT_W-1:0];
    assign o_side  = r_side[N-1];

endmodule

FILE: rtl/tfn_div.sv
module tfn_div (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  logic [tfn_pkg::ROOT_W-1:0]              i_root,
    input  tfn_pkg::t_side                          i_side,
    output logic                                    o_valid,
    output logic                                    o_deg,
    output logic [2:0][tfn_pkg::UNIT_W-1:0]         o_unit
);

    localparam int RW = tfn_pkg::REM_W;
    localparam int QN = tfn_pkg::Q_W;

    logic [tfn_pkg::ROOT_W-1:0]  r_i_root;
    logic [2:0][RW-1:0]          r_i_rem;
    logic                        r_i_v;
    tfn_pkg::t_side              r_i_side;

    logic [tfn_pkg::ROOT_W-1:0]  r_root[QN];
    logic [2:0][RW-1:0]          r_rem [QN];
    logic [2:0][QN-1:0]          r_q   [QN];
    logic                        r_v   [QN];
    tfn_pkg::t_side              r_side[QN];

    logic                                r_o_v, r_o_deg;
    logic [2:0][tfn_pkg::UNIT_W-1:0]     r_o_unit;

    logic [tfn_pkg::ROOT_W-1:0] root_nz;
    assign root_nz = (i_root == '0) ? tfn_pkg::ROOT_W'(1) : i_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            r_i_v <= i_valid;
            r_o_v <= r_v[QN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_i_root <= root_nz;
        r_i_side <= i_side;
        for (int k = 0; k < 3; k++)
            r_i_rem[k] <= (RW'(i_side.m[k])
                          << (tfn_pkg::NORMAL_FRAC_BITS + tfn_pkg::EDGE_BITS))
                        + RW'(root_nz >> 1);
    end

    for (genvar s = 0; s < QN; s++) begin : g_step
        logic [tfn_pkg::ROOT_W-1:0] src_root;
        logic [2:0][RW-1:0]         src_rem;
        logic [2:0][QN-1:0]         src_q;
        logic                       src_v;
        tfn_pkg::t_side             src_side;
        logic [RW-1:0]              dsh;
        if (s == 0) begin : g_first
            assign src_root = r_i_root;
            assign src_rem  = r_i_rem;
            assign src_q    = '0;
            assign src_v    = r_i_v;
            assign src_side = r_i_side;
        end else begin : g_next
            assign src_root = r_root[s-1];
            assign src_rem  = r_rem[s-1];
            assign src_q    = r_q[s-1];
            assign src_v    = r_v[s-1];
            assign src_side = r_side[s-1];
        end
        assign dsh = RW'(src_root) << (QN - 1 - s);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            for (int k = 0; k < 3; k++) begin
                if (src_rem[k] >= dsh) begin
                    r_rem[s][k] <= src_rem[k] - dsh;
                    r_q[s][k]   <= src_q[k] | (QN'(1) << (QN - 1 - s));
                end else begin
                    r_rem[s][k] <= src_rem[k];
                    r_q[s][k]   <= src_q[k];
                end
            end
            r_root[s] <= src_root;
            r_side[s] <= src_side;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [tfn_pkg::UNIT_W-1:0] q;
        for (int k = 0; k < 3; k++) begin
            q = tfn_pkg::UNIT_W'(r_q[QN-1][k]);
            if (q > tfn_pkg::UNIT_W'(2 ** tfn_pkg::NORMAL_FRAC_BITS))
                q = tfn_pkg::UNIT_W'(2 ** tfn_pkg::NORMAL_FRAC_BITS);
            r_o_unit[k] <= r_side[QN-1].neg[k] ? -q : q;
        end
        r_o_deg <= r_side[QN-1].deg;
    end

    assign o_valid = r_o_v;
    assign o_deg   = r_o_deg;
    assign o_unit  = r_o_unit;

endmodule

FILE: rtl/tfn_cross.sv
module tfn_cross (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                i_deg,
    input  logic [2:0][tfn_pkg::UNIT_W-1:0]     i_a,
    input  logic [2:0][tfn_pkg::UNIT_W-1:0]     i_b,
    output logic                                o_valid,
    output logic                                o_deg,
    output logic [2:0][tfn_pkg::OUT_WIDTH-1:0]  o_n
);

    localparam int DW = tfn_pkg::DIFF_W;
    localparam int NF = tfn_pkg::NORMAL_FRAC_BITS;

    logic                               r_p_v, r_p_deg, r_o_v, r_o_deg;
    logic [5:0][tfn_pkg::PROD_W-1:0]    r_p;
    logic [2:0][tfn_pkg::OUT_WIDTH-1:0] r_o_n;
    logic [2:0][DW-1:0]                 d;

    function automatic logic signed [tfn_pkg::PROD_W-1:0] smul(
        input logic [tfn_pkg::UNIT_W-1:0] x,
        input logic [tfn_pkg::UNIT_W-1:0] y
    );
        return tfn_pkg::PROD_W'($signed(x) * $signed(y));
    endfunction

    function automatic logic [tfn_pkg::OUT_WIDTH-1:0] round_out(input logic [DW-1:0] n);
        logic          neg;
        logic [DW-1:0] m, v;
        neg = n[DW-1];
        m   = neg ? -n : n;
        m   = (m + DW'(2 ** (NF - 1))) >> NF;
        if (m > DW'(2 ** NF))
            m = DW'(2 ** NF);
        v = neg ? -m : m;
        return v[tfn_pkg::OUT_WIDTH-1:0];
    endfunction

    always_comb begin
        d[0] = DW'($signed(r_p[0])) - DW'($signed(r_p[1]));
        d[1] = DW'($signed(r_p[2])) - DW'($signed(r_p[3]));
        d[2] = DW'($signed(r_p[4])) - DW'($signed(r_p[5]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            r_p_v <= i_valid;
            r_o_v <= r_p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p[0]  <= smul(i_a[1], i_b[2]);
        r_p[1]  <= smul(i_a[2], i_b[1]);
        r_p[2]  <= smul(i_a[2], i_b[0]);
        r_p[3]  <= smul(i_a[0], i_b[2]);
        r_p[4]  <= smul(i_a[0], i_b[1]);
        r_p[5]  <= smul(i_a[1], i_b[0]);
        r_p_deg <= i_deg;
        for (int k = 0; k < 3; k++)
            r_o_n[k] <= r_p_deg ? '0 : round_out(d[k]);
        r_o_deg <= r_p_deg;
    end

    assign o_valid = r_o_v;
    assign o_deg   = r_o_deg;
    assign o_n     = r_o_n;

endmodule

FILE: rtl/triangle_face_normal.sv
// channel  | direction | handshake        | payload
// command  | in        | start, busy      | i_first_*, i_second_*, i_third_*
// result   | out       | o_valid strobe   | o_normal_x/y/z, o_degenerate
//
// One word accepted per cycle; busy is always low.
// The result path from start to o_valid runs through the 31-step square root
// pipeline and the 15-step divider that turns each edge into a unit vector.
// Synchronous active-low reset clears all valid bits; payload is not reset.
// The receiver cannot stall; every result is shown for one cycle only.
module triangle_face_normal (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [tfn_pkg::COORD_WIDTH-1:0]  i_first_x,
    input  logic signed [tfn_pkg::COORD_WIDTH-1:0]  i_first_y,
    input  logic signed [tfn_pkg::COORD_WIDTH-1:0]  i_first_z,
    input  logic signed [tfn_pkg::COORD_WIDTH-1:0]  i_second_x,
    input  logic signed [tfn_pkg::COORD_WIDTH-1:0]  i_second_y,
    input  logic signed [tfn_pkg::COORD_WIDTH-1:0]  i_second_z,
    input  logic signed [tfn_pkg::COORD_WIDTH-1:0]  i_third_x,
    input  logic signed [tfn_pkg::COORD_WIDTH-1:0]  i_third_y,
    input  logic signed [tfn_pkg::COORD_WIDTH-1:0]  i_third_z,
    output logic                                    o_valid,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0]    o_normal_x,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0]    o_normal_y,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0]    o_normal_z,
    output logic                                    o_degenerate
);

    localparam int EW = tfn_pkg::COORD_WIDTH + 1;

    logic [2:0][EW-1:0] e1, e2;
    logic               deg;

    assign busy = 1'b0;

    always_comb begin
        e1[0] = EW'(i_first_x) - EW'(i_second_x);
        e1[1] = EW'(i_first_y) - EW'(i_second_y);
        e1[2] = EW'(i_first_z) - EW'(i_second_z);
        e2[0] = EW'(i_first_x) - EW'(i_third_x);
        e2[1] = EW'(i_first_y) - EW'(i_third_y);
        e2[2] = EW'(i_first_z) - EW'(i_third_z);
    end
    assign deg = (e1 == '0) || (e2 == '0);

    logic                               f1_v, f2_v, s1_v, s2_v, d1_v, d2_v, d1_deg, d2_deg;
    logic [tfn_pkg::LEN_W-1:0]          f1_len, f2_len;
    logic [tfn_pkg::ROOT_W-1:0]         s1_root, s2_root;
    tfn_pkg::t_side                     f1_side, f2_side, s1_side, s2_side;
    logic [2:0][tfn_pkg::UNIT_W-1:0]    u1, u2;
    logic                               c_v, c_deg;
    logic [2:0][tfn_pkg::OUT_WIDTH-1:0] c_n;

    tfn_front u_front1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start), .i_deg(deg), .i_e(e1),
        .o_valid(f1_v), .o_len(f1_len), .o_side(f1_side)
    );
    tfn_front u_front2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start), .i_deg(deg), .i_e(e2),
        .o_valid(f2_v), .o_len(f2_len), .o_side(f2_side)
    );
    tfn_sqrt u_sqrt1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f1_v), .i_len(f1_len),
        .i_side(f1_side), .o_valid(s1_v), .o_root(s1_root), .o_side(s1_side)
    );
    tfn_sqrt u_sqrt2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f2_v), .i_len(f2_len),
        .i_side(f2_side), .o_valid(s2_v), .o_root(s2_root), .o_side(s2_side)
    );
    tfn_div u_div1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s1_v), .i_root(s1_root),
        .i_side(s1_side), .o_valid(d1_v), .o_deg(d1_deg), .o_unit(u1)
    );
    tfn_div u_div2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s2_v), .i_root(s2_root),
        .i_side(s2_side), .o_valid(d2_v), .o_deg(d2_deg), .o_unit(u2)
    );
    tfn_cross u_cross (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(d1_v & d2_v),
        .i_deg(d1_deg | d2_deg), .i_a(u2), .i_b(u1),
        .o_valid(c_v), .o_deg(c_deg), .o_n(c_n)
    );

    assign o_valid      = c_v;
    assign o_degenerate = c_deg;
    assign o_normal_x   = c_n[0];
    assign o_normal_y   = c_n[1];
    assign o_normal_z   = c_n[2];

endmodule

FILE: rtl/tfn_checker.sv
`include "triangle_face_normal_defines.svh"

module tfn_checker (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    start,
    input logic                                    busy,
    input logic                                    o_valid,
    input logic signed [tfn_pkg::OUT_WIDTH-1:0]    o_normal_x,
    input logic signed [tfn_pkg::OUT_WIDTH-1:0]    o_normal_y,
    input logic signed [tfn_pkg::OUT_WIDTH-1:0]    o_normal_z,
    input logic                                    o_degenerate
);

    localparam int LAT = tfn_pkg::PIPE_LAT;
    localparam logic signed [tfn_pkg::OUT_WIDTH-1:0] LIM =
        tfn_pkg::OUT_WIDTH'(2 ** tfn_pkg::NORMAL_FRAC_BITS);

    `TFN_ASSERT_IMPLY(a_word_out, i_clk, i_rst_n, start && !busy, ##LAT o_valid)
    `TFN_ASSERT_IMPLY(a_no_spurious, i_clk, i_rst_n, o_valid, $past(start && i_rst_n, LAT))
    `TFN_ASSERT_IMPLY(a_deg_zero, i_clk, i_rst_n, o_valid && o_degenerate,
        o_normal_x == '0 && o_normal_y == '0 && o_normal_z == '0)
    `TFN_ASSERT_IMPLY(a_range, i_clk, i_rst_n, o_valid,
        o_normal_x <= LIM && o_normal_x >= -LIM && o_normal_y <= LIM &&
        o_normal_y >= -LIM && o_normal_z <= LIM && o_normal_z >= -LIM)

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_valid(o_valid),
    .o_normal_x(o_normal_x), .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
    .o_degenerate(o_degenerate)
);

FILE: tb/triangle_face_normal_test.sv
module triangle_face_normal_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM   = 1330;
    localparam int CALM_TAIL  = 150;
    localparam int UNIT_ONE   = 1 << tfn_pkg::NORMAL_FRAC_BITS;

    typedef logic signed [tfn_pkg::COORD_WIDTH-1:0] t_coord;
    typedef logic signed [tfn_pkg::OUT_WIDTH-1:0]   t_comp;
    typedef longint t_vec3 [3];

    typedef struct {
        t_coord p [9];
    } t_tri;

    typedef struct packed {
        t_comp nx;
        t_comp ny;
        t_comp nz;
        logic  deg;
    } t_normal;

    typedef struct {
        t_coord  p [9];
        bit      typed;
        t_normal want;
    } t_row;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    t_coord vx [9];
    logic   o_valid;
    t_comp  o_normal_x, o_normal_y, o_normal_z;
    logic   o_degenerate;

    t_normal pending_normals [$];
    t_normal typed_normals [$];
    bit      typed_flags [$];
    int      mismatches = 0;
    int      words_sent = 0;
    int      words_checked = 0;
    int      degenerate_seen = 0;

    initial for (int i = 0; i < 9; i++) vx[i] = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    triangle_face_normal DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_first_x   (vx[0]),
        .i_first_y   (vx[1]),
        .i_first_z   (vx[2]),
        .i_second_x  (vx[3]),
        .i_second_y  (vx[4]),
        .i_second_z  (vx[5]),
        .i_third_x   (vx[6]),
        .i_third_y   (vx[7]),
        .i_third_z   (vx[8]),
        .o_valid     (o_valid),
        .o_normal_x  (o_normal_x),
        .o_normal_y  (o_normal_y),
        .o_normal_z  (o_normal_z),
        .o_degenerate(o_degenerate)
    );

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res = 0;
        longint unsigned b = 64'h1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic void unit_edge(input t_vec3 e, output t_vec3 u);
        longint unsigned m [3];
        longint unsigned mx = 0, len2 = 0, r, q;
        for (int i = 0; i < 3; i++) begin
            m[i] = (e[i] < 0) ? -e[i] : e[i];
            if (m[i] > mx) mx = m[i];
        end
        while (mx >= (64'h1 << tfn_pkg::EDGE_BITS)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        for (int i = 0; i < 3; i++) len2 += m[i] * m[i];
        r = int_sqrt(len2 << 30);
        if (r == 0) r = 1;
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << (tfn_pkg::NORMAL_FRAC_BITS + tfn_pkg::EDGE_BITS)) + (r >> 1)) / r;
            if (q > UNIT_ONE) q = UNIT_ONE;
            u[i] = (e[i] < 0) ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic t_comp round_comp(longint n);
        longint unsigned m = (n < 0) ? -n : n;
        longint v;
        m = (m + (64'h1 << (tfn_pkg::NORMAL_FRAC_BITS - 1))) >> tfn_pkg::NORMAL_FRAC_BITS;
        if (m > UNIT_ONE) m = UNIT_ONE;
        v = (n < 0) ? -longint'(m) : longint'(m);
        return t_comp'(v);
    endfunction

    function automatic t_normal face_normal(t_coord p [9]);
        t_vec3 e1, e2, a, b;
        t_normal r;
        for (int i = 0; i < 3; i++) begin
            e1[i] = longint'(p[i]) - longint'(p[3+i]);
            e2[i] = longint'(p[i]) - longint'(p[6+i]);
        end
        r.nx = '0; r.ny = '0; r.nz = '0; r.deg = 1'b1;
        if ((e1[0] == 0 && e1[1] == 0 && e1[2] == 0) ||
            (e2[0] == 0 && e2[1] == 0 && e2[2] == 0))
            return r;
        unit_edge(e2, a);
        unit_edge(e1, b);
        r.nx  = round_comp(a[1]*b[2] - a[2]*b[1]);
        r.ny  = round_comp(a[2]*b[0] - a[0]*b[2]);
        r.nz  = round_comp(a[0]*b[1] - a[1]*b[0]);
        r.deg = 1'b0;
        return r;
    endfunction

    // accept and check, both sampled at the rising edge
    always @(posedge i_clk) begin
        t_coord  p [9];
        t_normal want, got;
        if (i_rst_n && start && !busy) begin
            for (int i = 0; i < 9; i++) p[i] = vx[i];
            want = face_normal(p);
            if (typed_flags.size() > 0 && typed_flags.pop_front())
                want = typed_normals.pop_front();
            pending_normals = {pending_normals, want};
        end
        if (i_rst_n && o_valid) begin
            got.nx = o_normal_x; got.ny = o_normal_y; got.nz = o_normal_z;
            got.deg = o_degenerate;
            if (got.deg) degenerate_seen++;
            if (pending_normals.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
            end else begin
                want = pending_normals.pop_front();
                words_checked++;
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d: want %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
                                 words_checked, want.nx, want.ny, want.nz, want.deg,
                                 got.nx, got.ny, got.nz, got.deg);
                end
            end
        end
    end

    task automatic send_word(t_coord p [9], bit typed, t_normal want, bit calm);
        if (!calm && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        typed_flags = {typed_flags, typed};
        if (typed) typed_normals = {typed_normals, want};
        start <= 1'b1;
        for (int i = 0; i < 9; i++) vx[i] <= p[i];
        do @(posedge i_clk); while (busy);
        words_sent++;
    endtask

    function automatic t_tri random_tri();
        t_tri t;
        int sel = $urandom_range(0, 9);
        int sh;
        for (int i = 0; i < 9; i++) t.p[i] = t_coord'($urandom());
        if (sel >= 2 && sel <= 7) begin
            // compact triangle around a random anchor
            sh = $urandom_range(0, 14);
            for (int i = 3; i < 9; i++)
                t.p[i] = t.p[i%3] + t_coord'($signed($urandom_range(0, 2 << sh)) - (1 << sh));
        end else if (sel == 8) begin
            for (int i = 0; i < 3; i++)
                if ($urandom_range(0, 1)) t.p[3+i] = t.p[i]; else t.p[6+i] = t.p[i];
        end else if (sel == 9) begin
            // collinear points
            for (int i = 0; i < 3; i++) begin
                t.p[i] = t_coord'($signed($urandom_range(0, 8000)) - 4000);
                t.p[3+i] = t_coord'(t.p[i] * 2);
                t.p[6+i] = t_coord'(t.p[i] * 3);
            end
        end
        return t;
    endfunction

    t_row dir_rows [$];

    function automatic t_row mk(int a0, a1, a2, b0, b1, b2, c0, c1, c2, bit typed,
                                int nx = 0, int ny = 0, int nz = 0, bit deg = 1'b0);
        t_row r;
        r.p[0] = t_coord'(a0); r.p[1] = t_coord'(a1); r.p[2] = t_coord'(a2);
        r.p[3] = t_coord'(b0); r.p[4] = t_coord'(b1); r.p[5] = t_coord'(b2);
        r.p[6] = t_coord'(c0); r.p[7] = t_coord'(c1); r.p[8] = t_coord'(c2);
        r.typed = typed;
        r.want.nx = t_comp'(nx); r.want.ny = t_comp'(ny); r.want.nz = t_comp'(nz);
        r.want.deg = deg;
        return r;
    endfunction

    function automatic void add_row(t_row r);
        dir_rows = {dir_rows, r};
    endfunction

    initial begin
        t_tri    t;
        t_normal none;
        none = '0;
        add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1));
        add_row(mk(5, 6, 7, 5, 6, 7, 1, 2, 3, 1, 0, 0, 0, 1));
        add_row(mk(5, 6, 7, 1, 2, 3, 5, 6, 7, 1, 0, 0, 0, 1));
        add_row(mk(-32768, -32768, -32768, -32768, -32768, -32768,
                   32767, 32767, 32767, 1, 0, 0, 0, 1));
        add_row(mk(0, 0, 0, -1, 0, 0, 0, -1, 0, 1, 0, 0, -UNIT_ONE, 0));
        add_row(mk(0, 0, 0, 0, -1, 0, -1, 0, 0, 1, 0, 0, UNIT_ONE, 0));
        add_row(mk(0, 0, 0, 0, 0, -1, 0, -1, 0, 1, UNIT_ONE, 0, 0, 0));
        add_row(mk(0, 0, 0, -1, 0, 0, 0, 0, -1, 1, 0, UNIT_ONE, 0, 0));
        add_row(mk(32767, 32767, 32767, -32768, -32768, -32768,
                   -32768, 32767, -32768, 0));
        add_row(mk(-32768, -32768, -32768, 32767, -32768, -32768,
                   -32768, 32767, -32768, 0));
        add_row(mk(32767, -32768, 32767, -32768, 32767, -32768,
                   32767, 32767, -32768, 0));
        add_row(mk(32767, 0, 0, -32768, 0, 0, 0, 32767, 0, 0));
        add_row(mk(1, 1, 1, 0, 0, 0, 2, 2, 2, 0));
        add_row(mk(256, 0, 0, 0, 256, 0, 0, 0, 256, 0));
        add_row(mk(0, 0, 0, 1, 1, 0, 1, -1, 0, 0));
        add_row(mk(100, -200, 300, -400, 500, -600, 700, 800, -900, 0));
        add_row(mk(-1, -1, -1, 0, 0, 0, 0, 1, 0, 0));
        add_row(mk(0, 0, 0, -16384, 16384, 0, 1, 0, 0, 0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k])
            send_word(dir_rows[k].p, dir_rows[k].typed, dir_rows[k].want, 1'b0);
        for (int n = 0; n < N_RANDOM; n++) begin
            t = random_tri();
            send_word(t.p, 1'b0, none, n >= N_RANDOM - CALM_TAIL);
        end
        start <= 1'b0;

        fork
            wait (pending_normals.size() == 0);
            repeat (2000) @(posedge i_clk);
        join_any
        disable fork;
        repeat (tfn_pkg::PIPE_LAT + 10) @(posedge i_clk);

        $display("%0d triangle words sent, %0d results checked, %0d flagged degenerate",
                 words_sent, words_checked, degenerate_seen);
        if (mismatches == 0 && pending_normals.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_normals.size());
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("run timed out");
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/tfn_pkg.sv
rtl/tfn_front.sv
rtl/tfn_sqrt.sv
rtl/tfn_div.sv
rtl/tfn_cross.sv
rtl/triangle_face_normal.sv
rtl/tfn_checker.sv
tb/triangle_face_normal_test.sv
